// ===== hdl/positional_ordered_list_top_assert.svh =====
// Assertion macros for the positional ordered list block.
// Used by the top level; no other dependencies.
`ifndef POSITIONAL_ORDERED_LIST_TOP_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define PLC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("plc assertion failed");
`define PLC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plc implication failed");
`else
`define PLC_ASSERT(lbl, clk, rst_n, prop)
`define PLC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/plc_pkg.sv =====
// Types shared by the positional ordered list block.
// No dependencies.
`default_nettype none

package plc_pkg;

  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_DEL_FRONT = 3'd2,
    MODE_DEL_BACK  = 3'd3,
    MODE_INS_AT    = 3'd4,
    MODE_DEL_AT    = 3'd5,
    MODE_LIST      = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] value;
    logic [5:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [31:0] element;
    status_e            status;
    logic [5:0]         element_count;
    logic               last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;        // run a modifying request
    logic list_empty;  // emit the empty marker
    logic list_first;  // start a list out
    logic list_step;   // emit front cell and rotate
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic list_end;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/plc_ctrl.sv =====
// Controller FSM for the positional ordered list block.
// Depends on plc_pkg.
`default_nettype none

module plc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire plc_pkg::mode_e    mode_i,
  input  wire plc_pkg::dp_stat_t stat_i,
  output logic                   busy_o,
  output plc_pkg::cmd_t          cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   accept;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_i)
            plc_pkg::MODE_INS_FRONT, plc_pkg::MODE_INS_BACK,
            plc_pkg::MODE_DEL_FRONT, plc_pkg::MODE_DEL_BACK,
            plc_pkg::MODE_INS_AT, plc_pkg::MODE_DEL_AT: begin
              cmd_o.exec = 1'b1;
            end
            plc_pkg::MODE_LIST: begin
              if (stat_i.count_zero) begin
                cmd_o.list_empty = 1'b1;
              end else begin
                cmd_o.list_first = 1'b1;
                state_d          = S_LIST;
              end
            end
            default: ;  // unused code: dropped
          endcase
        end
      end
      S_LIST: begin
        cmd_o.list_step = 1'b1;
        if (stat_i.list_end) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    busy_d = (state_d == S_LIST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/plc_dp.sv =====
// Datapath for the positional ordered list block: cell row, count, result register.
// Depends on plc_pkg.
`default_nettype none

module plc_dp #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire plc_pkg::req_t req_i,
  input  wire plc_pkg::cmd_t cmd_i,
  output plc_pkg::dp_stat_t  stat_o,
  output logic               valid_o,
  output plc_pkg::res_t      res_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KW = ((CW > 6) ? CW : 6) + 1;

  logic [DATA_WIDTH-1:0] cells_q [CAPACITY];
  logic [DATA_WIDTH-1:0] cells_d [CAPACITY];
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         lidx_q, lidx_d;
  logic                  valid_q, valid_d;
  plc_pkg::res_t         res_q, res_d;

  logic [KW-1:0]         cnt_ext, pos_ext;
  logic                  full, empty, do_ins, do_del, list_end;
  logic [IW-1:0]         slot;
  plc_pkg::status_e      st;
  logic [63:0]           val64, elem64;
  logic [DATA_WIDTH-1:0] new_cell;

  assign cnt_ext  = KW'(count_q);
  assign pos_ext  = KW'(req_i.position);
  assign full     = (count_q == CW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign list_end = (lidx_q == count_q - CW'(1));
  assign val64    = {32'b0, req_i.value};
  assign new_cell = val64[DATA_WIDTH-1:0];
  assign elem64   = 64'(signed'(cells_q[0]));

  assign stat_o.count_zero = empty;
  assign stat_o.list_end   = list_end;

  // decode the modifying request
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    slot   = '0;
    st     = plc_pkg::ST_OK;
    case (req_i.mode)
      plc_pkg::MODE_INS_FRONT: begin
        if (full) st = plc_pkg::ST_FULL;
        else do_ins = 1'b1;
      end
      plc_pkg::MODE_INS_BACK: begin
        slot = IW'(count_q);
        if (full) st = plc_pkg::ST_FULL;
        else do_ins = 1'b1;
      end
      plc_pkg::MODE_DEL_FRONT: begin
        if (empty) st = plc_pkg::ST_EMPTY;
        else do_del = 1'b1;
      end
      plc_pkg::MODE_DEL_BACK: begin
        slot = IW'(count_q - CW'(1));
        if (empty) st = plc_pkg::ST_EMPTY;
        else do_del = 1'b1;
      end
      plc_pkg::MODE_INS_AT: begin
        slot = IW'(req_i.position - 6'd1);
        if (req_i.position == 6'd0 || pos_ext > cnt_ext + KW'(1)) st = plc_pkg::ST_BADPOS;
        else if (full) st = plc_pkg::ST_FULL;
        else do_ins = 1'b1;
      end
      plc_pkg::MODE_DEL_AT: begin
        slot = IW'(req_i.position - 6'd1);
        if (empty) st = plc_pkg::ST_EMPTY;
        else if (req_i.position == 6'd0 || pos_ext > cnt_ext) st = plc_pkg::ST_BADPOS;
        else do_del = 1'b1;
      end
      default: ;
    endcase
  end

  // next state of cells, count and result
  always_comb begin
    cells_d = cells_q;
    count_d = count_q;
    lidx_d  = lidx_q;
    valid_d = 1'b0;
    res_d   = res_q;
    if (cmd_i.exec) begin
      if (do_ins) count_d = count_q + CW'(1);
      if (do_del) count_d = count_q - CW'(1);
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_ins) begin
          if (IW'(i) > slot) cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
          else if (IW'(i) == slot) cells_d[i] = new_cell;
        end else if (do_del && IW'(i) >= slot) begin
          cells_d[i] = cells_q[(i + 1) % CAPACITY];
        end
      end
      valid_d             = 1'b1;
      res_d.element       = '0;
      res_d.status        = st;
      res_d.element_count = 6'(count_d);
      res_d.last          = 1'b1;
    end
    if (cmd_i.list_empty) begin
      valid_d             = 1'b1;
      res_d.element       = '0;
      res_d.status        = plc_pkg::ST_EMPTY;
      res_d.element_count = '0;
      res_d.last          = 1'b1;
    end
    if (cmd_i.list_first) lidx_d = '0;
    if (cmd_i.list_step) begin
      // rotate the occupied cells by one so the front cell always feeds the output
      for (int i = 0; i < CAPACITY; i++) begin
        if (CW'(i) < count_q) begin
          if (CW'(i) == count_q - CW'(1)) cells_d[i] = cells_q[0];
          else cells_d[i] = cells_q[(i + 1) % CAPACITY];
        end
      end
      lidx_d              = lidx_q + CW'(1);
      valid_d             = 1'b1;
      res_d.element       = elem64[31:0];
      res_d.status        = plc_pkg::ST_OK;
      res_d.element_count = 6'(count_q);
      res_d.last          = list_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lidx_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      lidx_q  <= lidx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
    res_q   <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== hdl/positional_ordered_list_top.sv =====
// Top level of the positional ordered list block: controller plus datapath.
// Depends on plc_pkg, plc_ctrl, plc_dp and the assertion macro header.
//
//   channel   handshake          payload
//   request   start_i / busy_o   req_i  (plc_pkg::req_t)
//   result    valid_o strobe     res_o  (plc_pkg::res_t)
//
// Modifying requests leave busy_o low; a new request may follow in the next cycle
// and its status is registered and shows in the cycle after acceptance.
// List out holds busy_o high while the controller is in S_LIST; elements come one a
// cycle, each one registered after an S_LIST step, as the occupied cells rotate past
// the front cell. An empty list gives a single marker in the cycle after acceptance.
// Reset clears the count and the result strobe; cell contents are not reset.
// Results are held for one cycle only; the receiver cannot stall them.
`default_nettype none
`include "positional_ordered_list_top_assert.svh"

module positional_ordered_list_top #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire plc_pkg::req_t req_i,
  output logic               busy_o,
  output logic               valid_o,
  output plc_pkg::res_t      res_o
);

  plc_pkg::cmd_t     cmd;
  plc_pkg::dp_stat_t stat;
  logic              mod_req;
  logic              list_req;
  logic              err_res;

  plc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .mode_i (req_i.mode),
    .stat_i (stat),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  plc_dp #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  assign mod_req  = start_i && !busy_o &&
                    (req_i.mode inside {plc_pkg::MODE_INS_FRONT, plc_pkg::MODE_INS_BACK,
                                        plc_pkg::MODE_DEL_FRONT, plc_pkg::MODE_DEL_BACK,
                                        plc_pkg::MODE_INS_AT, plc_pkg::MODE_DEL_AT});
  assign list_req = start_i && !busy_o && (req_i.mode == plc_pkg::MODE_LIST);
  assign err_res  = valid_o && (res_o.status != plc_pkg::ST_OK);

  `PLC_ASSERT_IMPL(a_mod_status, clk_i, rst_ni, mod_req, ##1 (valid_o && res_o.last))
  `PLC_ASSERT_IMPL(a_mid_list_busy, clk_i, rst_ni, valid_o && !res_o.last, busy_o)
  `PLC_ASSERT_IMPL(a_busy_from_list, clk_i, rst_ni, $rose(busy_o), $past(list_req))
  `PLC_ASSERT_IMPL(a_zero_element, clk_i, rst_ni, err_res, res_o.element == 32'sd0)

endmodule

`default_nettype wire

// ===== test/tb_positional_ordered_list_top.sv =====
// Self-checking testbench for positional_ordered_list_top: directed list edge cases,
// then random grow/shrink traffic checked against a behavioral list kept in the bench.
// Depends on plc_pkg and the positional_ordered_list_top RTL.
`timescale 1ns / 1ps

module tb_positional_ordered_list_top;

  localparam int CAPACITY = 32;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start  = 1'b0;
  plc_pkg::req_t req    = '0;
  logic          busy;
  logic          valid;
  plc_pkg::res_t res;

  positional_ordered_list_top #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(32)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .req_i  (req),
    .busy_o (busy),
    .valid_o(valid),
    .res_o  (res)
  );

  always #4 clk_i = ~clk_i;

  plc_pkg::req_t requests_to_send[$];
  plc_pkg::res_t list_answers[$];
  logic [31:0]   shadow_cells[CAPACITY];
  int            shadow_count = 0;
  int            gen_count = 0;      // count as seen by the generator, ahead of the block
  int            sender_idle_pct = 0;
  int            mismatches = 0;

  task automatic note_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one accepted request to the shadow list and queues the results it causes.
  function automatic void apply_to_list(plc_pkg::req_t r);
    plc_pkg::res_t    a;
    plc_pkg::status_e st;
    int               ins_at;
    int               del_at;
    st     = plc_pkg::ST_OK;
    ins_at = -1;
    del_at = -1;
    a      = '0;
    case (r.mode)
      plc_pkg::MODE_INS_FRONT, plc_pkg::MODE_INS_BACK: begin
        if (shadow_count >= CAPACITY) st = plc_pkg::ST_FULL;
        else ins_at = (r.mode == plc_pkg::MODE_INS_FRONT) ? 0 : shadow_count;
      end
      plc_pkg::MODE_DEL_FRONT, plc_pkg::MODE_DEL_BACK: begin
        if (shadow_count == 0) st = plc_pkg::ST_EMPTY;
        else del_at = (r.mode == plc_pkg::MODE_DEL_FRONT) ? 0 : shadow_count - 1;
      end
      plc_pkg::MODE_INS_AT: begin
        if (r.position < 1 || r.position > shadow_count + 1) st = plc_pkg::ST_BADPOS;
        else if (shadow_count >= CAPACITY) st = plc_pkg::ST_FULL;
        else ins_at = r.position - 1;
      end
      plc_pkg::MODE_DEL_AT: begin
        if (shadow_count == 0) st = plc_pkg::ST_EMPTY;
        else if (r.position < 1 || r.position > shadow_count) st = plc_pkg::ST_BADPOS;
        else del_at = r.position - 1;
      end
      plc_pkg::MODE_LIST: begin
        if (shadow_count == 0) begin
          a.status = plc_pkg::ST_EMPTY;
          a.last   = 1'b1;
          list_answers.push_back(a);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            a.element       = shadow_cells[i];
            a.status        = plc_pkg::ST_OK;
            a.element_count = shadow_count[5:0];
            a.last          = (i == shadow_count - 1);
            list_answers.push_back(a);
          end
        end
        return;
      end
      default: return;  // unused mode: no result
    endcase
    if (ins_at >= 0) begin
      for (int i = shadow_count; i > ins_at; i--) shadow_cells[i] = shadow_cells[i-1];
      shadow_cells[ins_at] = r.value;
      shadow_count++;
    end
    if (del_at >= 0) begin
      for (int i = del_at; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
      shadow_count--;
    end
    a.status        = st;
    a.element_count = shadow_count[5:0];
    a.last          = 1'b1;
    list_answers.push_back(a);
  endfunction

  // Queues one item and tracks the count it leaves, so the generator can aim positions.
  task automatic push_item(logic [2:0] m, logic [31:0] v, logic [5:0] p);
    plc_pkg::req_t r;
    r.mode     = plc_pkg::mode_e'(m);
    r.value    = v;
    r.position = p;
    requests_to_send.push_back(r);
    case (plc_pkg::mode_e'(m))
      plc_pkg::MODE_INS_FRONT, plc_pkg::MODE_INS_BACK: if (gen_count < CAPACITY) gen_count++;
      plc_pkg::MODE_DEL_FRONT, plc_pkg::MODE_DEL_BACK: if (gen_count > 0) gen_count--;
      plc_pkg::MODE_INS_AT:
        if (p >= 1 && p <= gen_count + 1 && gen_count < CAPACITY) gen_count++;
      plc_pkg::MODE_DEL_AT: if (gen_count > 0 && p >= 1 && p <= gen_count) gen_count--;
      default: ;
    endcase
  endtask

  // Mostly fills the list to capacity and drains it again, with noise in between.
  task automatic queue_random(int n);
    int          made;
    int          roll;
    bit          growing;
    logic [2:0]  m;
    logic [31:0] v;
    logic [5:0]  p;
    made    = 0;
    growing = (gen_count < CAPACITY / 2);
    while (made < n) begin
      if (growing && gen_count == CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (!growing && gen_count == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      if ($urandom_range(0, 39) == 0) growing = !growing;
      case ($urandom_range(0, 5))
        0:       v = 32'h7fff_ffff;
        1:       v = 32'h8000_0000;
        2:       v = 32'h0000_0000;
        3:       v = 32'hffff_ffff;
        default: v = $urandom;
      endcase
      p    = 6'($urandom_range(0, 63));
      roll = $urandom_range(0, 99);
      if (roll < 2) m = MODE_UNUSED;
      else if (roll < 12) m = plc_pkg::MODE_LIST;
      else if (growing ? roll < 72 : roll < 32) begin
        case ($urandom_range(0, 2))
          0:       m = plc_pkg::MODE_INS_FRONT;
          1:       m = plc_pkg::MODE_INS_BACK;
          default: m = plc_pkg::MODE_INS_AT;
        endcase
        if (m == plc_pkg::MODE_INS_AT) begin
          if ($urandom_range(0, 3) != 0) p = 6'($urandom_range(1, gen_count + 1));
          else if ($urandom_range(0, 1) == 0) p = 6'(gen_count + 2);
          else if ($urandom_range(0, 1) == 0) p = 6'd0;
        end
      end else begin
        case ($urandom_range(0, 2))
          0:       m = plc_pkg::MODE_DEL_FRONT;
          1:       m = plc_pkg::MODE_DEL_BACK;
          default: m = plc_pkg::MODE_DEL_AT;
        endcase
        if (m == plc_pkg::MODE_DEL_AT) begin
          if (gen_count > 0 && $urandom_range(0, 3) != 0) p = 6'($urandom_range(1, gen_count));
          else if ($urandom_range(0, 1) == 0) p = 6'(gen_count + 1);
          else if ($urandom_range(0, 1) == 0) p = 6'd0;
        end
      end
      push_item(m, v, p);
      if (m != MODE_UNUSED) made++;
    end
  endtask

  // Sender holds off until the queue is sent and every answer is back.
  task automatic wait_list_settled();
    do @(posedge clk_i);
    while (requests_to_send.size() != 0 || start || list_answers.size() != 0);
  endtask

  // Driver: an item is taken at an edge where start is high and busy is low.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_to_list(req);
      if (!start || !busy) begin
        if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          start <= 1'b1;
          req   <= requests_to_send.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results last one cycle and cannot be stalled.
  always @(posedge clk_i) begin : result_check
    plc_pkg::res_t want;
    if (rst_ni && valid === 1'b1) begin
      if (list_answers.size() == 0) begin
        note_mismatch("result with nothing expected");
      end else begin
        want = list_answers.pop_front();
        if (res.element !== want.element)
          note_mismatch($sformatf("element %h, want %h", res.element, want.element));
        if (res.status !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", res.status, want.status));
        if (res.element_count !== want.element_count)
          note_mismatch($sformatf("count %0d, want %0d", res.element_count,
                                  want.element_count));
        if (res.last !== want.last)
          note_mismatch($sformatf("last %b, want %b", res.last, want.last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 23;
    // directed: empty list, bad positions, extremes, middle insert and delete
    push_item(plc_pkg::MODE_LIST, 32'h0, 6'd0);
    push_item(plc_pkg::MODE_DEL_FRONT, 32'h0, 6'd0);
    push_item(plc_pkg::MODE_DEL_BACK, 32'h0, 6'd0);
    push_item(plc_pkg::MODE_DEL_AT, 32'h0, 6'd1);
    push_item(plc_pkg::MODE_INS_AT, 32'h1234_5678, 6'd0);
    push_item(plc_pkg::MODE_INS_AT, 32'h1234_5678, 6'd2);
    push_item(plc_pkg::MODE_INS_AT, 32'h0000_0001, 6'd1);
    push_item(plc_pkg::MODE_INS_FRONT, 32'h7fff_ffff, 6'd63);
    push_item(plc_pkg::MODE_INS_BACK, 32'h8000_0000, 6'd0);
    push_item(plc_pkg::MODE_INS_AT, 32'hffff_ffff, 6'd2);
    push_item(plc_pkg::MODE_INS_AT, 32'h0000_0000, 6'd5);
    push_item(plc_pkg::MODE_INS_AT, 32'haaaa_aaaa, 6'd63);
    push_item(plc_pkg::MODE_DEL_AT, 32'h0, 6'd0);
    push_item(plc_pkg::MODE_DEL_AT, 32'h0, 6'd6);
    push_item(plc_pkg::MODE_LIST, 32'h0, 6'd0);
    push_item(plc_pkg::MODE_DEL_AT, 32'h0, 6'd3);
    push_item(MODE_UNUSED, 32'hdead_beef, 6'd1);
    push_item(plc_pkg::MODE_DEL_FRONT, 32'h0, 6'd0);
    push_item(plc_pkg::MODE_DEL_BACK, 32'h0, 6'd0);
    push_item(plc_pkg::MODE_LIST, 32'h0, 6'd0);
    push_item(plc_pkg::MODE_DEL_AT, 32'h0, 6'd2);
    push_item(plc_pkg::MODE_INS_BACK, 32'h5555_5555, 6'd0);
    push_item(plc_pkg::MODE_LIST, 32'h0, 6'd0);
    wait_list_settled();

    queue_random(52);
    wait_list_settled();

    sender_idle_pct = 84;
    queue_random(52);
    wait_list_settled();

    sender_idle_pct = 0;
    queue_random(52);
    wait_list_settled();

    // ignored items may still be in flight; give stray results time to show
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && list_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
